// File: design/spas_pkg.sv
// ----------------------------------------------------------------------------
// spas_pkg
// Shared constants and types for the sparse polynomial add/sub block.
// ----------------------------------------------------------------------------
package spas_pkg;

    localparam int MAX_TERMS = 16;
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);
    localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    localparam int COEFF_W   = 32;
    localparam int DEG_W     = 16;
    localparam int RES_W     = COEFF_W + 1;
    localparam int TERM_W    = COEFF_W + DEG_W;
    localparam int IN_DATA_W  = ((TERM_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((RES_W + DEG_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - RES_W - DEG_W;

    localparam logic LIST_FIRST  = 1'b0;
    localparam logic LIST_SECOND = 1'b1;

    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_SUB = 1'b1;

    typedef struct packed {
        logic [DEG_W-1:0]          degree;
        logic signed [COEFF_W-1:0] coeff;
    } term_t;

    typedef struct packed {
        logic load;
        logic emit;
    } spas_cmd_t;

    typedef struct packed {
        logic out_free;
        logic merge_last;
    } spas_sts_t;

endpackage

// File: design/spas_ctrl.sv
// ----------------------------------------------------------------------------
// spas_ctrl
// Sequencer: loads terms, then steps the merge one fetch and one emit a term.
// ----------------------------------------------------------------------------
module spas_ctrl
    import spas_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    input  logic      s_tuser,
    input  logic      s_tlast,
    output logic      s_tready,
    input  spas_sts_t sts,
    output spas_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_FETCH = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_LOAD);
    assign cmd.load = s_tvalid && s_tready;
    assign cmd.emit = (state_reg == ST_EMIT) && sts.out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (cmd.load && (s_tuser == LIST_SECOND) && s_tlast) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (cmd.emit) begin
                    state_next = sts.merge_last ? ST_LOAD : ST_FETCH;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: design/spas_datapath.sv
// ----------------------------------------------------------------------------
// spas_datapath
// Term stores, counts, merge pointers, head compare/add and output register.
// ----------------------------------------------------------------------------
module spas_datapath
    import spas_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic                  cfg_data,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  spas_cmd_t             cmd,
    output spas_sts_t             sts,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

    term_t first_mem_reg  [MAX_TERMS];
    term_t second_mem_reg [MAX_TERMS];
    term_t rd_a_reg, rd_b_reg;
    term_t s_term;

    logic [CNT_W-1:0] cnt_a_reg, cnt_a_next;
    logic [CNT_W-1:0] cnt_b_reg, cnt_b_next;
    logic [CNT_W-1:0] idx_a_reg, idx_a_next;
    logic [CNT_W-1:0] idx_b_reg, idx_b_next;
    logic             mode_reg;

    logic                    out_valid_reg;
    logic                    out_last_reg;
    logic signed [RES_W-1:0] out_coeff_reg;
    logic [DEG_W-1:0]        out_deg_reg;

    logic                    wr_a, wr_b;
    logic                    have_a, have_b;
    logic                    take_a, take_b;
    logic signed [RES_W-1:0] ca, cb, cb_neg, csum, res_coeff;
    logic [DEG_W-1:0]        res_deg;
    logic [CNT_W-1:0]        step_a, step_b;

    assign s_term = term_t'(s_tdata[TERM_W-1:0]);
    assign wr_a = cmd.load && (s_tuser == LIST_FIRST)  && (cnt_a_reg < CNT_W'(MAX_TERMS));
    assign wr_b = cmd.load && (s_tuser == LIST_SECOND) && (cnt_b_reg < CNT_W'(MAX_TERMS));

    always_ff @(posedge aclk) begin
        if (wr_a) begin
            first_mem_reg[cnt_a_reg[IDX_W-1:0]] <= s_term;
        end
        rd_a_reg <= first_mem_reg[idx_a_reg[IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (wr_b) begin
            second_mem_reg[cnt_b_reg[IDX_W-1:0]] <= s_term;
        end
        rd_b_reg <= second_mem_reg[idx_b_reg[IDX_W-1:0]];
    end

    always_comb begin
        have_a = (idx_a_reg < cnt_a_reg);
        have_b = (idx_b_reg < cnt_b_reg);
        ca     = RES_W'(rd_a_reg.coeff);
        cb     = RES_W'(rd_b_reg.coeff);
        cb_neg = (mode_reg == MODE_SUB) ? -cb : cb;
        csum   = (mode_reg == MODE_SUB) ? (ca - cb) : (ca + cb);
        priority if (have_a && have_b && (rd_a_reg.degree == rd_b_reg.degree)) begin
            take_a    = 1'b1;
            take_b    = 1'b1;
            res_coeff = csum;
            res_deg   = rd_a_reg.degree;
        end else if (have_a && (!have_b || (rd_a_reg.degree > rd_b_reg.degree))) begin
            take_a    = 1'b1;
            take_b    = 1'b0;
            res_coeff = ca;
            res_deg   = rd_a_reg.degree;
        end else begin
            take_a    = 1'b0;
            take_b    = 1'b1;
            res_coeff = cb_neg;
            res_deg   = rd_b_reg.degree;
        end
        step_a = idx_a_reg + CNT_W'(take_a);
        step_b = idx_b_reg + CNT_W'(take_b);
    end

    assign sts.merge_last = (step_a == cnt_a_reg) && (step_b == cnt_b_reg);
    assign sts.out_free   = !out_valid_reg || m_tready;

    always_comb begin
        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        idx_a_next = idx_a_reg;
        idx_b_next = idx_b_reg;
        if (wr_a) begin
            cnt_a_next = cnt_a_reg + CNT_W'(1);
        end
        if (wr_b) begin
            cnt_b_next = cnt_b_reg + CNT_W'(1);
        end
        if (cmd.emit) begin
            if (sts.merge_last) begin
                cnt_a_next = '0;
                cnt_b_next = '0;
                idx_a_next = '0;
                idx_b_next = '0;
            end else begin
                idx_a_next = step_a;
                idx_b_next = step_b;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            idx_a_reg     <= '0;
            idx_b_reg     <= '0;
            mode_reg      <= MODE_ADD;
            out_valid_reg <= 1'b0;
        end else begin
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
            idx_a_reg <= idx_a_next;
            idx_b_reg <= idx_b_next;
            if (cfg_valid) begin
                mode_reg <= cfg_data;
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_coeff_reg <= res_coeff;
            out_deg_reg   <= res_deg;
            out_last_reg  <= sts.merge_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_deg_reg, out_coeff_reg};

endmodule

// File: design/sparse_polynomial_add_sub_top.sv
// ----------------------------------------------------------------------------
// sparse_polynomial_add_sub_top
// Adds or subtracts two sparse polynomials by an ordered merge of term lists.
// ----------------------------------------------------------------------------
// Input stream: one term per beat, s_tuser selects the list (0 first,
// 1 second), s_tlast marks the second list's closing term. Terms arrive in
// descending degree; each list holds up to MAX_TERMS terms, extra terms drop.
// Loading takes one beat per cycle. The closing beat of the second list
// starts the merge and drops s_tready until the last result is produced.
// Merge: one result at a time, a store read in the fetch state, then a
// compare/add into the output register in the emit state, up to first +
// second list length results, the final one flagged by m_tlast. A stall on
// m_tready holds the result and the merge. cfg_valid/cfg_data write subtract
// mode (0 add, 1 subtract); the user must do so only while idle (unenforced).
// Reset clears counts, mode and the output valid; term stores need no clear.
// ----------------------------------------------------------------------------
module sparse_polynomial_add_sub_top
    import spas_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data,      // subtract_mode
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,       // term_coeff[31:0], term_degree[47:32]
    input  logic                  s_tuser,       // list_select
    input  logic                  s_tlast,       // last_term
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,       // result_coeff[32:0], result_degree[48:33]
    output logic                  m_tlast        // result_last
);

    spas_cmd_t cmd;
    spas_sts_t sts;

    assign cfg_ready = 1'b1;

    spas_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    spas_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// File: design/spas_checker.sv
// ----------------------------------------------------------------------------
// spas_checker
// Port-level checks for the sparse polynomial add/sub block.
// ----------------------------------------------------------------------------
module spas_checker
    import spas_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  s_tuser,
    input logic                  s_tlast,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tlast
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result beat changed");

    a_merge_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser && s_tlast |=> !s_tready)
        else $error("input accepted right after merge start");

    a_no_load_mid_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready while merge results pending");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_DATA_W-1:RES_W+DEG_W] == '0))
        else $error("result pad bits not zero");

endmodule

bind sparse_polynomial_add_sub_top spas_checker u_spas_checker (.*);

// File: test/spas_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spas_tb_checker
// Watches the term, result and mode channels of the sparse polynomial block,
// keeps its own copy of both term lists and the mode, merges them when the
// second list closes and compares every result beat, field by field, with
// the oldest expected term. Hands the count of open expectations and the
// count of mismatches to the testbench top.
// ----------------------------------------------------------------------------
module spas_tb_checker
    import spas_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic                  cfg_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  m_tlast,
    output int                    expected_left,
    output int                    error_count
);

    typedef struct packed {
        logic signed [RES_W-1:0] coeff;
        logic [DEG_W-1:0]        degree;
        logic                    last;
    } result_term_t;

    term_t        first_terms [MAX_TERMS];
    term_t        second_terms[MAX_TERMS];
    int           first_count  = 0;
    int           second_count = 0;
    logic         poly_mode    = MODE_ADD;
    result_term_t expected_terms[$];
    int           mismatches   = 0;

    assign error_count = mismatches;

    initial expected_left = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < 100)
            $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic merge_polys();
        int                      a;
        int                      b;
        int                      i;
        logic                    take_first;
        logic                    take_both;
        logic signed [RES_W-1:0] ca;
        logic signed [RES_W-1:0] cb;
        result_term_t            r;
        result_term_t            merged[$];
        a = 0;
        b = 0;
        while (a < first_count || b < second_count) begin
            take_both  = 1'b0;
            take_first = 1'b0;
            if (a < first_count && b < second_count) begin
                take_both  = (first_terms[a].degree == second_terms[b].degree);
                take_first = (first_terms[a].degree > second_terms[b].degree);
            end else if (a < first_count) begin
                take_first = 1'b1;
            end
            ca = '0;
            cb = '0;
            if (take_both || take_first) begin
                ca       = $signed(first_terms[a].coeff);
                r.degree = first_terms[a].degree;
                a++;
            end
            if (!take_first) begin
                cb       = $signed(second_terms[b].coeff);
                r.degree = second_terms[b].degree;
                b++;
            end
            r.coeff = (poly_mode == MODE_SUB) ? ca - cb : ca + cb;
            r.last  = 1'b0;
            merged.push_back(r);
        end
        for (i = 0; i < merged.size(); i++) begin
            r      = merged[i];
            r.last = (i == merged.size() - 1);
            expected_terms.push_back(r);
        end
        first_count  = 0;
        second_count = 0;
    endtask

    task automatic load_term();
        term_t t;
        t = s_tdata[TERM_W-1:0];
        if (s_tuser == LIST_FIRST) begin
            if (first_count < MAX_TERMS) begin
                first_terms[first_count] = t;
                first_count++;
            end
        end else begin
            if (second_count < MAX_TERMS) begin
                second_terms[second_count] = t;
                second_count++;
            end
            if (s_tlast)
                merge_polys();
        end
    endtask

    task automatic check_result();
        result_term_t want;
        logic [RES_W-1:0] got_coeff;
        logic [DEG_W-1:0] got_degree;
        got_coeff  = m_tdata[RES_W-1:0];
        got_degree = m_tdata[RES_W +: DEG_W];
        if (expected_terms.size() == 0) begin
            report_mismatch("result beat with nothing pending", 64'(m_tdata), 64'(0));
        end else begin
            want = expected_terms.pop_front();
            if (got_coeff !== want.coeff)
                report_mismatch("result_coeff", 64'(got_coeff),
                                64'(unsigned'(want.coeff)));
            if (got_degree !== want.degree)
                report_mismatch("result_degree", 64'(got_degree), 64'(want.degree));
            if (m_tlast !== want.last)
                report_mismatch("result_last", 64'(m_tlast), 64'(want.last));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            first_count  = 0;
            second_count = 0;
            poly_mode    = MODE_ADD;
            expected_terms.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_result();
            if (cfg_valid && cfg_ready)
                poly_mode = cfg_data;
            if (s_tvalid && s_tready)
                load_term();
        end
        expected_left <= expected_terms.size();
    end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the sparse polynomial add/sub block with term lists: a short
// directed set for extreme values, list closing, overflow and empty lists,
// then random polynomial pairs in both modes with bursty input, a varying
// result stall pattern and occasional malformed sequences. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import spas_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_TERMS  = 300;

    typedef enum int {READY_ALWAYS, READY_COIN, READY_MOSTLY, READY_PERIODIC} ready_style_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_data  = MODE_ADD;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = LIST_FIRST;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    int                    expected_left;
    int                    error_count;
    int                    burst_left  = 0;
    int                    terms_sent  = 0;
    int unsigned           ready_cycle = 0;
    ready_style_t          ready_style = READY_ALWAYS;

    sparse_polynomial_add_sub_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    spas_tb_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .expected_left (expected_left),
        .error_count   (error_count)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge aclk) begin
        ready_cycle <= ready_cycle + 1;
        if (ready_cycle % 97 == 0)
            ready_style <= ready_style_t'($urandom_range(0, 3));
        case (ready_style)
            READY_ALWAYS: begin
                m_tready <= 1'b1;
            end
            READY_COIN: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            READY_MOSTLY: begin
                m_tready <= ($urandom_range(0, 5) != 0);
            end
            default: begin
                m_tready <= (ready_cycle % 5 < 2);
            end
        endcase
    end

    function automatic logic [COEFF_W-1:0] pick_coeff();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            3:       return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_term(input logic sel, input logic [COEFF_W-1:0] coeff,
                             input logic [DEG_W-1:0] degree, input logic last);
        int    gap;
        term_t t;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0
                : $urandom_range(1, ($urandom_range(0, 7) == 0) ? 20 : 4);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 12);
        end
        t.coeff  = coeff;
        t.degree = degree;
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'(t);
        s_tuser  <= sel;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        terms_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (expected_left != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input logic mode);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_list(input logic sel, input int n, input int top, input int step);
        int   d;
        int   i;
        logic mark;
        d = top;
        for (i = 0; i < n; i++) begin
            if (sel == LIST_SECOND)
                mark = (i == n - 1);
            else
                mark = (i == n - 1) && ($urandom_range(0, 3) != 0);
            send_term(sel, pick_coeff(), d[DEG_W-1:0], mark);
            d = d - $urandom_range(1, step);
        end
    endtask

    task automatic send_pair();
        int n_first;
        int n_second;
        int n_max;
        int step;
        int top;
        n_first  = ($urandom_range(0, 11) == 0) ? $urandom_range(14, 19)
                                                : $urandom_range(0, 6);
        n_second = ($urandom_range(0, 11) == 0) ? $urandom_range(14, 19)
                                                : $urandom_range(1, 6);
        n_max    = (n_first > n_second) ? n_first : n_second;
        if ($urandom_range(0, 3) == 0) begin
            step = 65535 / (n_max + 1);
            top  = $urandom_range(n_max * step, 65535);
        end else begin
            step = 3;
            top  = $urandom_range(n_max * step, n_max * step + 6);
        end
        send_list(LIST_FIRST, n_first, top, step);
        send_list(LIST_SECOND, n_second, top, step);
    endtask

    task automatic send_noise();
        int   n;
        int   i;
        logic sel;
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++) begin
            sel = 1'($urandom_range(0, 1));
            send_term(sel, pick_coeff(), DEG_W'($urandom_range(0, 65535)),
                      sel ? ($urandom_range(0, 3) == 0) : 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        int i;
        int pair_index;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_mode(MODE_ADD);
        send_term(LIST_FIRST,  32'h7fff_ffff, 16'hffff, 1'b0);
        send_term(LIST_FIRST,  32'h8000_0000, 16'h0000, 1'b1);
        send_term(LIST_SECOND, 32'h7fff_ffff, 16'hffff, 1'b0);
        send_term(LIST_SECOND, 32'h8000_0000, 16'h0000, 1'b1);

        write_mode(MODE_SUB);
        send_term(LIST_FIRST,  32'h8000_0000, 16'd7, 1'b1);
        send_term(LIST_SECOND, 32'h7fff_ffff, 16'd7, 1'b0);
        send_term(LIST_SECOND, 32'h8000_0000, 16'd3, 1'b1);

        // first list closed early, then appended; second list out of order
        send_term(LIST_FIRST,  32'd5, 16'd10, 1'b1);
        send_term(LIST_FIRST,  32'd1, 16'd2,  1'b0);
        send_term(LIST_SECOND, 32'd5, 16'd10, 1'b0);
        send_term(LIST_SECOND, 32'd9, 16'd20, 1'b1);

        // empty first list, second list overflows and its dropped beat closes it
        for (i = 0; i < MAX_TERMS + 1; i++)
            send_term(LIST_SECOND, pick_coeff(), DEG_W'(MAX_TERMS - i), i == MAX_TERMS);

        write_mode(MODE_ADD);

        terms_sent = 0;
        pair_index = 0;
        while (terms_sent < RANDOM_TERMS) begin
            if (pair_index == 10)
                wait_idle();
            if ($urandom_range(0, 5) == 0)
                write_mode(1'($urandom_range(0, 1)));
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                send_pair();
            pair_index++;
        end

        wait_idle();
        repeat (20) @(posedge aclk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
